// ===== rtl/planar_odometry_integrator_top_defines.svh =====
// ----------------------------------------------------------------------------
// planar odometry integrator assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef PLANAR_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH

// checked only outside reset
`define POI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("odometry integrator check failed");

// checked on every edge, reset included
`define POI_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("odometry integrator reset check failed");

`endif

// ===== rtl/poi_pkg.sv =====
// ----------------------------------------------------------------------------
// poi_pkg
// types, widths and constants of the planar odometry integrator
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POSITION_BITS_DEF = 56;

  localparam int CORDIC_W   = 36;
  localparam int ZW         = 34;
  localparam int ANGLE_W    = 32;
  localparam int ATAN_DEPTH = 32;
  localparam int ATAN_IDX_W = 5;
  localparam int HEADING_W  = 36;
  localparam int OUT_POS_W  = 56;
  localparam int GAIN_W     = 31;

  localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
  localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 32'h2000_0000;

  typedef struct packed {
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_lateral;
    logic signed [23:0] yaw_rate;
    logic [20:0]        elapsed_ticks;
  } in_t;

  typedef struct packed {
    logic signed [OUT_POS_W-1:0] pos_x_out;
    logic signed [OUT_POS_W-1:0] pos_y_out;
    logic [15:0]                 heading_out;
    logic signed [15:0]          quat_z;
    logic signed [15:0]          quat_w;
    logic                        saturated;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [ANGLE_W-1:0] angle;
  } rot_ctl_t;

  function automatic logic [ANGLE_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/poi_rotator.sv =====
// ----------------------------------------------------------------------------
// poi_rotator
// quarter-turn fold and iterative cordic rotation, one micro-rotation a cycle
// ----------------------------------------------------------------------------
module poi_rotator #(
  parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  poi_pkg::rot_ctl_t                     ctl,
  input  logic signed [poi_pkg::CORDIC_W-1:0]   x_in,
  input  logic signed [poi_pkg::CORDIC_W-1:0]   y_in,
  output logic                                  done,
  output logic signed [poi_pkg::CORDIC_W-1:0]   x_out,
  output logic signed [poi_pkg::CORDIC_W-1:0]   y_out
);
  import poi_pkg::*;

  localparam int ITERS = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;
  localparam int ITW   = $clog2(ITERS);

  logic signed [CORDIC_W-1:0] x, y;
  logic signed [ZW-1:0]       z;
  logic [ITW-1:0]             iter;
  logic                       busy;

  logic [ANGLE_W-1:0]         qsum, res;
  logic [1:0]                 quad;
  logic signed [CORDIC_W-1:0] x_ld, y_ld, dx, dy, x_step, y_step;
  logic signed [ZW-1:0]       z_ld, z_step, atan_z;

  always_comb begin
    qsum = ctl.angle + EIGHTH_TURN;
    quad = qsum[ANGLE_W-1 -: 2];
    res  = ctl.angle - {quad, {(ANGLE_W-2){1'b0}}};
    z_ld = ZW'($signed(res));
    unique case (quad)
      2'd0: begin x_ld = x_in;  y_ld = y_in;  end
      2'd1: begin x_ld = -y_in; y_ld = x_in;  end
      2'd2: begin x_ld = -x_in; y_ld = -y_in; end
      2'd3: begin x_ld = y_in;  y_ld = -x_in; end
      default: begin x_ld = x_in; y_ld = y_in; end
    endcase
  end

  always_comb begin
    dx     = y >>> iter;
    dy     = x >>> iter;
    atan_z = ZW'(atan_entry(ATAN_IDX_W'(iter)));
    if (!z[ZW-1]) begin
      x_step = x - dx;
      y_step = y + dy;
      z_step = z - atan_z;
    end else begin
      x_step = x + dx;
      y_step = y - dy;
      z_step = z + atan_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        x    <= x_ld;
        y    <= y_ld;
        z    <= z_ld;
        iter <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        x    <= x_step;
        y    <= y_step;
        z    <= z_step;
        iter <= iter + 1'b1;
        if (iter == ITW'(ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign x_out = x;
  assign y_out = y;

endmodule

// ===== rtl/planar_odometry_integrator_top.sv =====
// ----------------------------------------------------------------------------
// planar_odometry_integrator_top
// dead-reckoning odometry for a holonomic planar base
// ----------------------------------------------------------------------------
// in_data carries body-frame velocities, yaw rate and elapsed time; a
// transaction completes when in_valid and in_ready are both high. out_data
// carries the new position, heading, half-heading quaternion and a clip flag,
// one result per input, under out_valid / out_ready.
// in_ready is high only while the sequencer is idle. One multiplier and one
// cordic rotator are shared: two gain products, a rotation of the velocity by
// the old heading, two time products, the heading product, then a rotation
// for the quaternion by the new heading.
// The time from input transaction to out_valid is set mainly by the two serial
// rotations (steps capped at 32); a new item is taken only once the
// sequencer has returned to idle from its last step.
// The result sits in an output register; while the receiver stalls the next
// item is accepted and computed, and it waits in its last step until the
// pending result is taken.
// Synchronous reset clears position, heading and the handshake state.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_top #(
  parameter int CORDIC_STEPS  = poi_pkg::CORDIC_STEPS_DEF,
  parameter int POSITION_BITS = poi_pkg::POSITION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  poi_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output poi_pkg::out_t out_data
);
  import poi_pkg::*;

  localparam int MW      = CORDIC_W + GAIN_W;
  localparam int DELTA_W = 42;
  localparam int SUM_W   = ((POSITION_BITS > DELTA_W) ? POSITION_BITS : DELTA_W) + 1;

  localparam logic signed [SUM_W-1:0] POS_HI =
    {{(SUM_W-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_LO = ~POS_HI;
  localparam logic signed [MW-1:0] PROD_RND = MW'(32768);
  localparam logic signed [CORDIC_W:0] Q15_RND = (CORDIC_W+1)'(16384);
  localparam logic signed [CORDIC_W:0] Q15_MAX = (CORDIC_W+1)'(32767);
  localparam logic signed [CORDIC_W:0] Q15_MIN = -(CORDIC_W+1)'(32768);

  typedef enum logic [3:0] {
    S_IDLE, S_PRE_X, S_PRE_Y, S_ROT_V, S_WAIT_V, S_MUL_X, S_MUL_Y,
    S_MUL_H, S_HEAD, S_ROT_Q, S_WAIT_Q, S_DONE
  } state_t;

  function automatic logic [POSITION_BITS:0] sat_add(
    input logic signed [POSITION_BITS-1:0] p,
    input logic signed [DELTA_W-1:0]       d
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(d);
    if (s > POS_HI) begin
      return {1'b1, POS_HI[POSITION_BITS-1:0]};
    end else if (s < POS_LO) begin
      return {1'b1, POS_LO[POSITION_BITS-1:0]};
    end
    return {1'b0, s[POSITION_BITS-1:0]};
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [CORDIC_W-1:0] c);
    logic signed [CORDIC_W:0] r;
    r = ((CORDIC_W+1)'(c) + Q15_RND) >>> 15;
    if (r > Q15_MAX) begin
      return 16'sh7fff;
    end else if (r < Q15_MIN) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  state_t                            state;
  in_t                               item;
  logic signed [MW-1:0]              prod;
  logic signed [CORDIC_W-1:0]        vx_pre;
  logic signed [POSITION_BITS-1:0]   pos_x, pos_y;
  logic [HEADING_W-1:0]              heading;
  logic                              sat_flag;

  logic signed [CORDIC_W-1:0]        mul_a;
  logic signed [GAIN_W-1:0]          mul_b;
  logic signed [MW-1:0]              prod_rnd;
  logic signed [DELTA_W-1:0]         delta;
  logic [POSITION_BITS:0]            sat_res;
  logic signed [POSITION_BITS-1:0]   pos_sel;
  logic signed [GAIN_W-1:0]          ticks_s;

  rot_ctl_t                          rot_ctl;
  logic signed [CORDIC_W-1:0]        rot_x_in, rot_y_in, rot_x, rot_y;
  logic                              rot_done;

  assign ticks_s  = $signed({{(GAIN_W-21){1'b0}}, item.elapsed_ticks});
  assign prod_rnd = prod + PROD_RND;
  assign delta    = DELTA_W'(prod_rnd >>> 16);
  assign pos_sel  = (state == S_MUL_Y) ? pos_x : pos_y;
  assign sat_res  = sat_add(pos_sel, delta);

  always_comb begin
    mul_a = CORDIC_W'(item.vel_forward);
    mul_b = GAIN_Q30;
    unique case (state)
      S_PRE_Y: mul_a = CORDIC_W'(item.vel_lateral);
      S_MUL_X: begin mul_a = rot_x; mul_b = ticks_s; end
      S_MUL_Y: begin mul_a = rot_y; mul_b = ticks_s; end
      S_MUL_H: begin mul_a = CORDIC_W'(item.yaw_rate); mul_b = ticks_s; end
      default: ;
    endcase
  end

  always_comb begin
    rot_ctl.start = (state == S_ROT_V) || (state == S_ROT_Q);
    if (state == S_ROT_Q) begin
      rot_ctl.angle = {1'b0, heading[HEADING_W-1 -: ANGLE_W-1]};
      rot_x_in      = CORDIC_W'(GAIN_Q30);
      rot_y_in      = '0;
    end else begin
      rot_ctl.angle = heading[HEADING_W-1 -: ANGLE_W];
      rot_x_in      = vx_pre;
      rot_y_in      = CORDIC_W'(prod >>> 14);
    end
  end

  poi_rotator #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_rotator (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rot_ctl),
    .x_in  (rot_x_in),
    .y_in  (rot_y_in),
    .done  (rot_done),
    .x_out (rot_x),
    .y_out (rot_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pos_x     <= '0;
      pos_y     <= '0;
      heading   <= '0;
      sat_flag  <= 1'b0;
    end else begin
      prod <= mul_a * mul_b;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item     <= in_data;
            sat_flag <= 1'b0;
            state    <= S_PRE_X;
          end
        end
        S_PRE_X: state <= S_PRE_Y;
        S_PRE_Y: begin
          vx_pre <= CORDIC_W'(prod >>> 14);
          state  <= S_ROT_V;
        end
        S_ROT_V: state <= S_WAIT_V;
        S_WAIT_V: begin
          if (rot_done) begin
            state <= S_MUL_X;
          end
        end
        S_MUL_X: state <= S_MUL_Y;
        S_MUL_Y: begin
          pos_x    <= sat_res[POSITION_BITS-1:0];
          sat_flag <= sat_flag | sat_res[POSITION_BITS];
          state    <= S_MUL_H;
        end
        S_MUL_H: begin
          pos_y    <= sat_res[POSITION_BITS-1:0];
          sat_flag <= sat_flag | sat_res[POSITION_BITS];
          state    <= S_HEAD;
        end
        S_HEAD: begin
          heading <= heading + prod[HEADING_W-1:0];
          state   <= S_ROT_Q;
        end
        S_ROT_Q: state <= S_WAIT_Q;
        S_WAIT_Q: begin
          if (rot_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.pos_x_out   <= OUT_POS_W'(pos_x);
            out_data.pos_y_out   <= OUT_POS_W'(pos_y);
            out_data.heading_out <= heading[HEADING_W-1 -: 16];
            out_data.quat_z      <= q15(rot_y);
            out_data.quat_w      <= q15(rot_x);
            out_data.saturated   <= sat_flag;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

// ===== rtl/poi_checker.sv =====
// ----------------------------------------------------------------------------
// poi_checker
// port-level checks of the odometry integrator, bound to the top level
// ----------------------------------------------------------------------------
`include "planar_odometry_integrator_top_defines.svh"

module poi_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input poi_pkg::out_t out_data
);
  import poi_pkg::*;

  // a stalled result holds
  `POI_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))
  // one transaction at a time: input side closes after a transaction
  `POI_ASSERT(a_in_busy, clk, rst, in_valid && in_ready |=> !in_ready)
  // with the output empty, an accepted input is not followed straight away by a result
  `POI_ASSERT(a_no_early, clk, rst, in_valid && in_ready && !out_valid |=> ##1 !out_valid)
  // reset empties the output register
  `POI_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)

endmodule

bind planar_odometry_integrator_top poi_checker u_poi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// testbench of planar_odometry_integrator_top: a directed table followed by
// random velocity, yaw rate and elapsed time transactions, with random idling
// on both sides and one long output stall. every result is compared field by
// field with a bit-exact fixed-point odometry predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import poi_pkg::*;

  localparam int     STEPS       = CORDIC_STEPS_DEF;
  localparam int     POS_BITS    = POSITION_BITS_DEF;
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam int     ITEM_COUNT  = 1550;
  localparam int     CALM_TAIL   = 150;
  localparam int     HOLD_AFTER  = 250;
  localparam int     HOLD_CYCLES = 500;
  localparam int     AT_REST_ROWS = 3;

  typedef enum logic [1:0] {QUAD_NONE, QUAD_LEFT, QUAD_BACK, QUAD_RIGHT} quadrant_e;

  localparam longint ARCTAN_Q32 [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  // vel_forward, vel_lateral, yaw_rate, elapsed_ticks
  localparam in_t DIRECTED [19] = '{
    '{16'sd0, 16'sd0, 24'sd0, 21'd0},
    '{16'sd32767, -16'sd32768, 24'sd8388607, 21'd0},
    '{-16'sd32768, 16'sd32767, -24'sd8388608, 21'd0},
    '{16'sd32767, 16'sd0, 24'sd0, 21'd1048576},
    '{16'sd0, 16'sd32767, 24'sd0, 21'd1048576},
    '{-16'sd32768, -16'sd32768, 24'sd16384, 21'd1048576},
    '{16'sd12000, -16'sd7000, 24'sd16384, 21'd1048576},
    '{-16'sd5000, 16'sd30000, 24'sd16384, 21'd1048576},
    '{16'sd20000, 16'sd20000, 24'sd16384, 21'd1048576},
    '{16'sd32767, 16'sd32767, 24'sd8192, 21'd1048576},
    '{16'sd32767, -16'sd32768, 24'sd8388607, 21'd2097151},
    '{-16'sd32768, -16'sd32768, -24'sd8388608, 21'd2097151},
    '{16'sd1, -16'sd1, 24'sd1, 21'd1},
    '{-16'sd1, 16'sd1, -24'sd1, 21'd2097151},
    '{16'sd32767, 16'sd32767, 24'sd0, 21'd1048577},
    '{-16'sd32768, 16'sd32767, -24'sd16384, 21'd524288},
    '{16'sd0, 16'sd0, -24'sd1, 21'd1},
    '{16'sd21845, -16'sd21846, 24'sd5592405, 21'd1398101},
    '{-16'sd21846, 16'sd21845, -24'sd5592406, 21'd699050}
  };

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  longint  track_x;
  longint  track_y;
  logic [HEADING_W-1:0] track_heading;
  out_t    pose_queue [$];
  out_t    want;
  int      errors = 0;
  int      sent = 0;
  int      taken = 0;
  bit      calm = 1'b0;
  bit      held = 1'b0;

  planar_odometry_integrator_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic void cordic_turn(inout longint x, inout longint y,
                                      input logic [31:0] ang);
    logic [31:0] sum;
    logic [31:0] resid;
    quadrant_e   quad;
    longint      z;
    longint      t;
    longint      dx;
    longint      dy;
    sum = ang + 32'h2000_0000;
    quad = quadrant_e'(sum[31:30]);
    resid = ang - {sum[31:30], 30'd0};
    z = longint'($signed(resid));
    case (quad)
      QUAD_LEFT: begin
        t = x; x = -y; y = t;
      end
      QUAD_BACK: begin
        x = -x; y = -y;
      end
      QUAD_RIGHT: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARCTAN_Q32[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARCTAN_Q32[i];
      end
    end
  endfunction

  function automatic longint clip_add(input longint p, input longint d, inout bit clipped);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (POS_BITS - 1)) - 1;
    lo = -hi - 1;
    if (p > hi) p = hi;
    if (p < lo) p = lo;
    if (d > 0 && p > hi - d) begin
      clipped = 1'b1;
      return hi;
    end
    if (d < 0 && p < lo - d) begin
      clipped = 1'b1;
      return lo;
    end
    return p + d;
  endfunction

  function automatic logic [15:0] to_q15(input longint c);
    longint v;
    v = (c + 16384) >>> 15;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // integrate one velocity sample into the tracked pose
  function automatic out_t advance_pose(input in_t d);
    longint fx;
    longint fy;
    longint ticks;
    longint rate;
    longint step_x;
    longint step_y;
    longint cw;
    longint sz;
    bit     clipped;
    out_t   r;
    clipped = 1'b0;
    ticks = longint'(d.elapsed_ticks);
    rate = longint'($signed(d.yaw_rate));
    fx = (longint'($signed(d.vel_forward)) * CORDIC_GAIN) >>> 14;
    fy = (longint'($signed(d.vel_lateral)) * CORDIC_GAIN) >>> 14;
    cordic_turn(fx, fy, track_heading[35:4]);
    step_x = (fx * ticks + 32768) >>> 16;
    step_y = (fy * ticks + 32768) >>> 16;
    track_x = clip_add(track_x, step_x, clipped);
    track_y = clip_add(track_y, step_y, clipped);
    track_heading = track_heading + HEADING_W'(rate * ticks);
    cw = CORDIC_GAIN;
    sz = 0;
    cordic_turn(cw, sz, {1'b0, track_heading[35:5]});
    r.pos_x_out   = track_x[OUT_POS_W-1:0];
    r.pos_y_out   = track_y[OUT_POS_W-1:0];
    r.heading_out = track_heading[35:20];
    r.quat_z      = to_q15(sz);
    r.quat_w      = to_q15(cw);
    r.saturated   = clipped;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic offer(input in_t d, input bit at_rest);
    out_t pose;
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pose = advance_pose(d);
    // pose unchanged from reset: known values
    if (at_rest) begin
      pose.pos_x_out   = '0;
      pose.pos_y_out   = '0;
      pose.heading_out = '0;
      pose.quat_w      = 16'sd32767;
      pose.saturated   = 1'b0;
    end
    pose_queue.push_back(pose);
    sent++;
    if (sent >= ITEM_COUNT - CALM_TAIL) calm = 1'b1;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  initial begin
    in_t d;
    track_x = 0;
    track_y = 0;
    track_heading = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < $size(DIRECTED); i++) begin
      offer(DIRECTED[i], i < AT_REST_ROWS);
    end
    while (sent < ITEM_COUNT) begin
      d.vel_forward = 16'($urandom);
      d.vel_lateral = 16'($urandom);
      d.yaw_rate    = 24'($urandom);
      case ($urandom_range(0, 7))
        0: d.elapsed_ticks = '0;
        1: d.elapsed_ticks = '1;
        2: d.elapsed_ticks = 21'($urandom_range(0, 1023));
        default: d.elapsed_ticks = 21'($urandom_range(0, 2097151));
      endcase
      offer(d, 1'b0);
    end
    in_valid <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (2 * STEPS + 20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    wait (!rst);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      taken++;
      if (pose_queue.size() == 0) begin
        flag_error("result transaction with nothing expected");
      end else begin
        want = pose_queue.pop_front();
        if (out_data.pos_x_out !== want.pos_x_out)
          flag_error($sformatf("pos_x_out got %0h want %0h",
                               out_data.pos_x_out, want.pos_x_out));
        if (out_data.pos_y_out !== want.pos_y_out)
          flag_error($sformatf("pos_y_out got %0h want %0h",
                               out_data.pos_y_out, want.pos_y_out));
        if (out_data.heading_out !== want.heading_out)
          flag_error($sformatf("heading_out got %0h want %0h",
                               out_data.heading_out, want.heading_out));
        if (out_data.quat_z !== want.quat_z)
          flag_error($sformatf("quat_z got %0h want %0h", out_data.quat_z, want.quat_z));
        if (out_data.quat_w !== want.quat_w)
          flag_error($sformatf("quat_w got %0h want %0h", out_data.quat_w, want.quat_w));
        if (out_data.saturated !== want.saturated)
          flag_error($sformatf("saturated got %0b want %0b",
                               out_data.saturated, want.saturated));
      end
    end
  end

  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/poi_pkg.sv
rtl/poi_rotator.sv
rtl/planar_odometry_integrator_top.sv
rtl/poi_checker.sv
verif/tb.sv
